FILE: src/tlf_pkg.sv
// Shared types and constants for the text line folder.
// Used by tlf_front, tlf_queue, tlf_back and text_line_folder_top; depends on nothing.
package tlf_pkg;

   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] MASK_HIGH  = 8'd128;
   localparam logic [7:0] MASK_LEAD  = 8'd192;

   localparam int CHUNK_BYTES = 8;
   localparam int CNT_W       = 4;
   localparam int CHUNK_W     = 8 * CHUNK_BYTES;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One input word after classification.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_final;
      logic       is_delim;   // ';', ':' or space
      logic       is_lead;    // plain ASCII or UTF-8 lead byte
   } item_type;

endpackage

FILE: src/text_line_folder_top.sv
// Top level of the text line folder: content-line folding of a byte stream.
// Depends on tlf_pkg, tlf_front, tlf_queue and tlf_back.
//
//   Channel  Direction  Word carries
//   -------  ---------  -------------------------------------------------------
//   req_*    in         one text byte; tlast marks the final byte of the text
//   rsp_*    out        a chunk of 1 to 8 bytes; tlast ends the results of one
//                       input word; tuser flags a fold or the end of the text
//
// A byte that neither fills the line window nor ends the text is taken by the
// back part while it is idle, so such bytes stream at one per cycle while the
// back part is not emitting chunks, after the input register and the queue.
// A byte that fills the window sends the back part through a break search and
// then ceil(k/8) output chunks; the final byte adds ceil(remaining/8) more
// chunks. The chunk sequencer in the back part steps through these chunks.
// Reset is synchronous and active high; it empties the queue and the window.
// Either side may stall on its own: the queue and the result register keep
// the input side moving while a finished chunk waits to be taken.
module text_line_folder_top #(
   parameter int LINE_LIMIT = 75
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // is_final
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] chunk, [67:64] chunk_bytes, [71:68] zero
   output logic        rsp_tlast,   // run_end
   output logic [1:0]  rsp_tuser    // [0] fold_after, [1] text_end
);
   import tlf_pkg::*;

   logic     front_valid, front_ready;
   item_type front_item;
   logic     queue_valid, queue_pop;
   item_type queue_item;

   // Front: registers each byte and tags it as delimiter or lead byte.
   tlf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (front_valid),
      .item       (front_item),
      .item_ready (front_ready)
   );

   // Queue: decouples the front from the chunk sequencer.
   tlf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop        (queue_pop),
      .pop_item   (queue_item)
   );

   // Back: holds the window, picks the break point and emits the chunks.
   tlf_back #(
      .LINE_LIMIT (LINE_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (queue_item),
      .item_pop   (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: src/tlf_front.sv
// Input stage of the text line folder: registers and classifies each word.
// Depends on tlf_pkg.
module tlf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,
   input  logic              req_tlast,
   output logic              item_valid,
   output tlf_pkg::item_type item,
   input  logic              item_ready
);
   import tlf_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign req_tready = !valid_ff || item_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      item_in.text_byte = req_tdata;
      item_in.is_final  = req_tlast;
      item_in.is_delim  = (req_tdata == CHAR_SEMI) || (req_tdata == CHAR_COLON) ||
                          (req_tdata == CHAR_SPACE);
      item_in.is_lead   = ((req_tdata & MASK_HIGH) == 8'd0) ||
                          ((req_tdata & MASK_LEAD) == MASK_LEAD);
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

endmodule

FILE: src/tlf_queue.sv
// Short queue of classified words between the front and back parts.
// Depends on tlf_pkg.
module tlf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tlf_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop,
   output tlf_pkg::item_type pop_item
);
   import tlf_pkg::*;

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: src/tlf_back.sv
// Back part of the text line folder: line window, break search, chunk sequencer
// and result register. Depends on tlf_pkg.
module tlf_back #(
   parameter int LINE_LIMIT = 75
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  tlf_pkg::item_type item,
   output logic              item_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,
   output logic              rsp_tlast,
   output logic [1:0]        rsp_tuser
);
   import tlf_pkg::*;

   localparam int FILL_W = $clog2(LINE_LIMIT + 1);
   localparam int POS_W  = $clog2(LINE_LIMIT);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [7:0]            win_ff [LINE_LIMIT];
   logic [7:0]            win_in [LINE_LIMIT];
   logic [LINE_LIMIT-1:0] delim_ff, delim_in;
   logic [LINE_LIMIT-1:0] lead_ff, lead_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [FILL_W-1:0]     remain_ff, remain_in;
   logic                  fold_mode_ff, fold_mode_in;
   logic                  final_ff, final_in;

   logic                  out_valid_ff, out_valid_in;
   logic [CHUNK_W-1:0]    out_chunk_ff, out_chunk_in;
   logic [CNT_W-1:0]      out_cnt_ff;
   logic                  out_fold_ff, out_fold_in;
   logic                  out_run_end_ff, out_run_end_in;
   logic                  out_text_end_ff, out_text_end_in;

   logic                  out_free, out_load;
   logic [FILL_W-1:0]     k_lead, k_calc;
   logic [CNT_W-1:0]      cnt;
   logic                  last_chunk;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_cnt_ff, out_chunk_ff};
   assign rsp_tlast  = out_run_end_ff;
   assign rsp_tuser  = {out_text_end_ff, out_fold_ff};

   // Break search over the full window: a delimiter wins over a lead byte.
   always_comb begin
      k_lead = FILL_W'(LINE_LIMIT - 1);
      for (int p = 1; p <= LINE_LIMIT - 1; p++) begin
         if (lead_ff[p]) k_lead = FILL_W'(p);
      end
      k_calc = k_lead;
      for (int p = 1; p <= LINE_LIMIT - 2; p++) begin
         if (delim_ff[p]) k_calc = FILL_W'(p + 1);
      end
   end

   // Current chunk taken from the bottom of the window.
   always_comb begin
      last_chunk = remain_ff <= FILL_W'(CHUNK_BYTES);
      cnt        = last_chunk ? CNT_W'(remain_ff) : CNT_W'(CHUNK_BYTES);
      for (int j = 0; j < CHUNK_BYTES; j++) begin
         out_chunk_in[8*j +: 8] = (CNT_W'(j) < cnt) ? win_ff[j] : 8'd0;
      end
      out_fold_in     = last_chunk && fold_mode_ff;
      out_text_end_in = last_chunk && !fold_mode_ff;
      out_run_end_in  = last_chunk && !(fold_mode_ff && final_ff);
   end

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      delim_in     = delim_ff;
      lead_in      = lead_ff;
      fill_in      = fill_ff;
      remain_in    = remain_ff;
      fold_mode_in = fold_mode_ff;
      final_in     = final_ff;
      item_pop     = 1'b0;
      out_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               win_in[fill_ff[POS_W-1:0]]   = item.text_byte;
               delim_in[fill_ff[POS_W-1:0]] = item.is_delim;
               lead_in[fill_ff[POS_W-1:0]]  = item.is_lead;
               fill_in  = fill_ff + FILL_W'(1);
               final_in = item.is_final;
               if (fill_ff == FILL_W'(LINE_LIMIT - 1)) begin
                  state_in = ST_SEARCH;
               end else if (item.is_final) begin
                  fold_mode_in = 1'b0;
                  remain_in    = fill_ff + FILL_W'(1);
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_SEARCH: begin
            remain_in    = k_calc;
            fold_mode_in = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               for (int s = 1; s <= CHUNK_BYTES; s++) begin
                  if (cnt == CNT_W'(s)) begin
                     for (int i = 0; i + s < LINE_LIMIT; i++) begin
                        win_in[i]   = win_ff[i + s];
                        delim_in[i] = delim_ff[i + s];
                        lead_in[i]  = lead_ff[i + s];
                     end
                  end
               end
               fill_in   = fill_ff - FILL_W'(cnt);
               remain_in = remain_ff - FILL_W'(cnt);
               if (last_chunk) begin
                  if (fold_mode_ff && final_ff) begin
                     fold_mode_in = 1'b0;
                     remain_in    = fill_ff - FILL_W'(cnt);
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         remain_ff    <= '0;
         fold_mode_ff <= 1'b0;
         final_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         remain_ff    <= remain_in;
         fold_mode_ff <= fold_mode_in;
         final_ff     <= final_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      delim_ff <= delim_in;
      lead_ff  <= lead_in;
      if (out_load) begin
         out_chunk_ff    <= out_chunk_in;
         out_cnt_ff      <= cnt;
         out_fold_ff     <= out_fold_in;
         out_run_end_ff  <= out_run_end_in;
         out_text_end_ff <= out_text_end_in;
      end
   end

endmodule

FILE: tb/tb.sv
// Self-checking testbench for text_line_folder_top: streams text bytes in, folds them in
// a local line window of its own, and compares every result chunk against that prediction.
// Depends on tlf_pkg and text_line_folder_top.
`timescale 1ns / 100ps

module tb;
   import tlf_pkg::*;

   localparam int LINE_LIMIT = 75;

   // One input word: a text byte and the flag that ends the text.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       is_final;
   } text_item_type;

   // One result word as it should leave the block.
   typedef struct packed {
      logic [63:0] chunk;
      logic [3:0]  nbytes;
      logic        fold;
      logic        run_end;
      logic        text_end;
   } line_chunk_type;

   // Kinds of random text content, chosen to steer the break search.
   typedef enum int {
      FLAV_WORDS,   // letters with frequent ';', ':' and spaces
      FLAV_UTF8,    // mostly continuation bytes, some lead bytes, rare delimiters
      FLAV_CONT,    // continuation bytes only, so no break point exists
      FLAV_NOISE    // any byte value
   } text_flavor_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] text_byte
   logic        req_tlast = 1'b0;     // is_final
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;            // [63:0] chunk, [67:64] chunk_bytes, [71:68] zero
   logic        rsp_tlast;            // run_end
   logic [1:0]  rsp_tuser;            // [0] fold_after, [1] text_end

   text_line_folder_top #(
      .LINE_LIMIT (LINE_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Words waiting to be sent, the predicted chunks still to arrive, and the chunks
   // produced by the word currently being folded.
   text_item_type  text_q[$];
   line_chunk_type chunks_due[$];
   line_chunk_type step_chunks[$];

   // The predictor's own copy of the line window.
   logic [7:0] line_win [LINE_LIMIT];
   int         line_fill = 0;

   int             mismatch_count = 0;
   int             send_wait = 0;
   int             take_wait = 0;
   bit             send_calm = 1'b0;
   bit             take_calm = 1'b0;
   logic           req_taken = 1'b0;
   text_item_type  next_item;
   line_chunk_type got_chunk;
   line_chunk_type want_chunk;

   // ------------------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------------------

   // Break point for a full window: just after the last delimiter at positions
   // LINE_LIMIT-2 down to 1, else just before the last ASCII or lead byte at
   // positions LINE_LIMIT-1 down to 1, else a hard break at LINE_LIMIT-1.
   function automatic int break_point();
      for (int p = LINE_LIMIT - 2; p >= 1; p--) begin
         if (line_win[p] == CHAR_SEMI || line_win[p] == CHAR_COLON ||
             line_win[p] == CHAR_SPACE) begin
            return p + 1;
         end
      end
      for (int p = LINE_LIMIT - 1; p >= 1; p--) begin
         if (line_win[p][7] == 1'b0 || line_win[p][7:6] == 2'b11) begin
            return p;
         end
      end
      return LINE_LIMIT - 1;
   endfunction

   // Cuts the first len bytes of the window into chunks of up to eight bytes.
   // The fold and end-of-text flags go on the last chunk of the run only.
   task automatic emit_run(input int len, input bit fold, input bit tend);
      int             pos;
      int             cnt;
      line_chunk_type c;
      pos = 0;
      while (pos < len) begin
         cnt = (len - pos > 8) ? 8 : len - pos;
         c = '0;
         for (int i = 0; i < cnt; i++) begin
            c.chunk[8*i +: 8] = line_win[pos + i];
         end
         pos += cnt;
         c.nbytes   = cnt[3:0];
         c.fold     = fold && (pos == len);
         c.text_end = tend && (pos == len);
         step_chunks.push_back(c);
      end
   endtask

   // Folds one accepted word into the window and queues the chunks it causes.
   task automatic fold_step(input logic [7:0] b, input logic last);
      int             k;
      line_chunk_type c;
      step_chunks.delete();
      line_win[line_fill] = b;
      line_fill++;
      if (line_fill == LINE_LIMIT) begin
         k = break_point();
         emit_run(k, 1'b1, 1'b0);
         for (int i = 0; i < line_fill - k; i++) begin
            line_win[i] = line_win[i + k];
         end
         line_fill -= k;
      end
      // A final byte that also completed the window flushes what the fold left.
      if (last) begin
         emit_run(line_fill, 1'b0, 1'b1);
         line_fill = 0;
      end
      foreach (step_chunks[i]) begin
         c = step_chunks[i];
         c.run_end = (i == step_chunks.size() - 1);
         chunks_due.push_back(c);
      end
   endtask

   // ------------------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------------------

   function automatic logic [7:0] pick_byte(text_flavor_type flav);
      int roll;
      int which;
      roll  = $urandom_range(0, 99);
      which = $urandom_range(0, 2);
      case (flav)
         FLAV_WORDS: begin
            if (roll < 5) return CHAR_SEMI;
            if (roll < 10) return CHAR_COLON;
            if (roll < 22) return CHAR_SPACE;
            return 8'(8'h61 + $urandom_range(0, 25));
         end
         FLAV_UTF8: begin
            if (roll < 2) begin
               return (which == 0) ? CHAR_SEMI : ((which == 1) ? CHAR_COLON : CHAR_SPACE);
            end
            if (roll < 12) return 8'(8'hC0 + $urandom_range(0, 63));
            return 8'(8'h80 + $urandom_range(0, 63));
         end
         FLAV_CONT: begin
            return 8'(8'h80 + $urandom_range(0, 63));
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic last);
      text_item_type it;
      it.text_byte = b;
      it.is_final  = last;
      text_q.push_back(it);
   endtask

   task automatic add_text(input int len, input text_flavor_type flav);
      for (int i = 0; i < len; i++) begin
         push_byte(pick_byte(flav), i == len - 1);
      end
   endtask

   // Idle cycles before the next word: long calm stretches with no idling, and
   // otherwise a random gap, one time in four from a wide range, else from a narrow one.
   task automatic draw_wait(inout bit calm, output int cycles);
      if ($urandom_range(0, 15) == 0) calm = !calm;
      if (calm) begin
         cycles = 0;
      end else if ($urandom_range(0, 3) == 0) begin
         cycles = $urandom_range(0, 18);
      end else begin
         cycles = $urandom_range(0, 3);
      end
   endtask

   task automatic report_mismatch(input string field, input logic [71:0] want,
                                  input logic [71:0] got);
      if (mismatch_count < 30) begin
         $display("%0t: %s expected %h got %h", $realtime, field, want, got);
      end
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------------------
   // Request driver: presents queued words at the falling edge and moves on once the
   // current word has been taken at a rising edge.
   // ------------------------------------------------------------------------------------

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (send_wait > 0) begin
            send_wait = send_wait - 1;
            req_tvalid <= 1'b0;
            req_tdata  <= 8'($urandom_range(0, 255));
            req_tlast  <= 1'($urandom_range(0, 1));
         end else if (text_q.size() > 0) begin
            next_item = text_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_item.text_byte;
            req_tlast  <= next_item.is_final;
            draw_wait(send_calm, send_wait);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Accepted request words feed the predictor.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            fold_step(req_tdata, req_tlast);
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Result monitor: ready stalls at random after each taken word, and every taken word
   // is checked field by field against the oldest predicted chunk.
   // ------------------------------------------------------------------------------------

   always @(negedge clock) begin
      if (!reset) begin
         if (take_wait > 0) begin
            take_wait = take_wait - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_chunk.chunk    = rsp_tdata[63:0];
         got_chunk.nbytes   = rsp_tdata[67:64];
         got_chunk.fold     = rsp_tuser[0];
         got_chunk.run_end  = rsp_tlast;
         got_chunk.text_end = rsp_tuser[1];
         if (chunks_due.size() == 0) begin
            report_mismatch("unexpected chunk", '0, 72'(got_chunk));
         end else begin
            want_chunk = chunks_due.pop_front();
            if (got_chunk.chunk !== want_chunk.chunk)
               report_mismatch("chunk", 72'(want_chunk.chunk), 72'(got_chunk.chunk));
            if (got_chunk.nbytes !== want_chunk.nbytes)
               report_mismatch("chunk_bytes", 72'(want_chunk.nbytes), 72'(got_chunk.nbytes));
            if (rsp_tdata[71:68] !== 4'h0)
               report_mismatch("tdata padding", '0, 72'(rsp_tdata[71:68]));
            if (got_chunk.fold !== want_chunk.fold)
               report_mismatch("fold_after", 72'(want_chunk.fold), 72'(got_chunk.fold));
            if (got_chunk.run_end !== want_chunk.run_end)
               report_mismatch("run_end", 72'(want_chunk.run_end), 72'(got_chunk.run_end));
            if (got_chunk.text_end !== want_chunk.text_end)
               report_mismatch("text_end", 72'(want_chunk.text_end),
                               72'(got_chunk.text_end));
         end
         draw_wait(take_calm, take_wait);
      end
   end

   // ------------------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------------------

   initial begin
      // Directed texts: three one-byte texts, two of them at the byte extremes, a text holding every
      // byte class that spills into a second chunk, and a text of exactly one chunk.
      push_byte(8'h41, 1'b1);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(CHAR_SEMI, 1'b0);
      push_byte(CHAR_COLON, 1'b0);
      push_byte(CHAR_SPACE, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hC0, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h5A, 1'b1);
      for (int i = 0; i < 8; i++) begin
         push_byte(8'(8'h30 + i), i == 7);
      end

      // Random texts. The first has no break byte at all and its final byte fills the
      // window, so the hard fold and the flush land on one word. The second runs past
      // the window, so a fold leaves bytes behind that later bytes join before the flush.
      add_text(LINE_LIMIT, FLAV_CONT);
      add_text(LINE_LIMIT + 5, text_flavor_type'($urandom_range(0, 3)));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the last word to be taken and its chunks to drain, then give the
      // block some more cycles in case it produces anything extra.
      while (text_q.size() > 0 || req_tvalid) @(posedge clock);
      while (chunks_due.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("text_line_folder_top: match");
      end else begin
         $display("text_line_folder_top: mismatch");
      end
      $finish;
   end

   // Run limit, far above the slowest legal run of this stimulus.
   initial begin
      #(64'd20_000_000);
      $display("text_line_folder_top: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
src/tlf_pkg.sv
src/tlf_front.sv
src/tlf_queue.sv
src/tlf_back.sv
src/text_line_folder_top.sv
tb/tb.sv
